[hdl/pbi_pkg.sv]
// ----------------------------------------------------------------------------
// pbi_pkg: shared types and constants for the periodic boundary image core
// Sizes, sample and job types, and the front/back classification codes.
// ----------------------------------------------------------------------------
package pbi_pkg;

    localparam int MAX_ROWS    = 1024;
    localparam int MAX_COLS    = 1024;
    localparam int SAMPLE_BITS = 24;
    localparam int VAL_W       = SAMPLE_BITS + 2;
    localparam int POS_W       = 10;
    localparam int SIZE_W      = 11;
    localparam int COL_AW      = $clog2(MAX_COLS);

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 2'd1;

    // queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = Q_AW + 1;

    typedef enum logic [1:0] {
        CL_NONE,
        CL_BOT,
        CL_LCOL,
        CL_CORNER
    } t_class;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] re;
        logic signed [SAMPLE_BITS-1:0] im;
    } t_cval;

    // effective image geometry, derived from the size registers
    typedef struct packed {
        logic [SIZE_W-1:0] rows;
        logic [SIZE_W-1:0] cols;
        logic [POS_W-1:0]  lr;
        logic [POS_W-1:0]  lc;
    } t_geom;

    // p: pixel, m: top row store read, d: first pixel of row, a: top-left pixel
    typedef struct packed {
        t_class           cls;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        t_cval            p;
        t_cval            m;
        t_cval            d;
        t_cval            a;
    } t_job;

endpackage

[hdl/periodic_boundary_image_core.sv]
// ----------------------------------------------------------------------------
// periodic_boundary_image_core: boundary-jump image of a raster pixel stream
// Path: a pixel is registered in the front stage, queued as a job and each
// result issued through the output register. Intake: one pixel per cycle
// unless stalled; the single result sequencer issues a job's two or four results in turn.
// A four-entry job queue absorbs the difference between the two sides.
// Reset: synchronous, clears control, sizes to 1024 x 1024, row-first to zero.
// ----------------------------------------------------------------------------
module periodic_boundary_image_core
    import pbi_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [SIZE_W-1:0]             i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [POS_W-1:0]              i_pix_row,
    input  logic [POS_W-1:0]              i_pix_col,
    input  logic signed [SAMPLE_BITS-1:0] i_pix_re,
    input  logic signed [SAMPLE_BITS-1:0] i_pix_im,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [POS_W-1:0]              o_out_row,
    output logic [POS_W-1:0]              o_out_col,
    output logic signed [VAL_W-1:0]       o_out_re,
    output logic signed [VAL_W-1:0]       o_out_im,
    output logic                          o_out_last
);

    logic [SIZE_W-1:0] r_num_rows;
    logic [SIZE_W-1:0] r_num_cols;
    t_geom             w_geom;
    logic              w_push;
    logic              w_pop;
    logic              w_q_full;
    logic              w_q_empty;
    t_job              w_job_in;
    t_job              w_job_head;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows <= SIZE_W'(MAX_ROWS);
            r_num_cols <= SIZE_W'(MAX_COLS);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_NUM_ROWS: r_num_rows <= i_cfg_data;
                CFG_NUM_COLS: r_num_cols <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // out-of-range sizes are clamped to 2..max
    always_comb begin
        if (r_num_rows < SIZE_W'(2)) begin
            w_geom.rows = SIZE_W'(2);
        end else if (r_num_rows > SIZE_W'(MAX_ROWS)) begin
            w_geom.rows = SIZE_W'(MAX_ROWS);
        end else begin
            w_geom.rows = r_num_rows;
        end
        if (r_num_cols < SIZE_W'(2)) begin
            w_geom.cols = SIZE_W'(2);
        end else if (r_num_cols > SIZE_W'(MAX_COLS)) begin
            w_geom.cols = SIZE_W'(MAX_COLS);
        end else begin
            w_geom.cols = r_num_cols;
        end
        w_geom.lr = POS_W'(w_geom.rows - 1'b1);
        w_geom.lc = POS_W'(w_geom.cols - 1'b1);
    end

    pbi_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_geom     (w_geom),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_pix_row  (i_pix_row),
        .i_pix_col  (i_pix_col),
        .i_pix_re   (i_pix_re),
        .i_pix_im   (i_pix_im),
        .i_q_full   (w_q_full),
        .o_push     (w_push),
        .o_job      (w_job_in)
    );

    pbi_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .i_pop   (w_pop),
        .o_head  (w_job_head),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    pbi_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_geom      (w_geom),
        .i_job       (w_job_head),
        .i_q_empty   (w_q_empty),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_out_re    (o_out_re),
        .o_out_im    (o_out_im),
        .o_out_last  (o_out_last)
    );

    // no transfer into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_full)
        else $error("job queue overflow");

    // the input only stalls while the queue holds jobs
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> !w_q_empty)
        else $error("input stalled with empty queue");

    // the final marker only comes with the bottom-right corner
    a_last_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_last) |-> (o_out_row == w_geom.lr && o_out_col == w_geom.lc))
        else $error("last marker away from bottom-right corner");

    // a result that is not taken stays on the output
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_re) && $stable(o_out_im)))
        else $error("stalled result changed");

endmodule

[hdl/pbi_front.sv]
// ----------------------------------------------------------------------------
// pbi_front: pixel intake and classification
// Takes pixels, updates the top row store and row-first register, and hands
// boundary jobs with their operands to the job queue.
// ----------------------------------------------------------------------------
module pbi_front
    import pbi_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_geom                         i_geom,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [POS_W-1:0]              i_pix_row,
    input  logic [POS_W-1:0]              i_pix_col,
    input  logic signed [SAMPLE_BITS-1:0] i_pix_re,
    input  logic signed [SAMPLE_BITS-1:0] i_pix_im,
    input  logic                          i_q_full,
    output logic                          o_push,
    output t_job                          o_job
);

    t_cval r_top_mem [MAX_COLS];
    t_cval r_row_first;
    t_cval r_top_first;
    logic  r_s1_valid;
    t_job  r_s1;

    logic             accept;
    logic             in_range;
    t_class           cls;
    t_cval            pix;
    logic [COL_AW-1:0] rd_addr;
    logic [COL_AW-1:0] wr_addr;

    assign pix        = '{re: i_pix_re, im: i_pix_im};
    assign o_in_stall = r_s1_valid & i_q_full;
    assign accept     = i_in_valid & ~o_in_stall;
    assign in_range   = ({1'b0, i_pix_row} < i_geom.rows) &&
                        ({1'b0, i_pix_col} < i_geom.cols);
    assign wr_addr    = i_pix_col[COL_AW-1:0];

    always_comb begin
        if (!in_range) begin
            cls = CL_NONE;
        end else if (i_pix_row == i_geom.lr && i_pix_col != '0 &&
                     i_pix_col != i_geom.lc) begin
            cls = CL_BOT;
        end else if (i_pix_col == i_geom.lc && i_pix_row != '0 &&
                     i_pix_row != i_geom.lr) begin
            cls = CL_LCOL;
        end else if (i_pix_row == i_geom.lr && i_pix_col == i_geom.lc) begin
            cls = CL_CORNER;
        end else begin
            cls = CL_NONE;
        end
    end

    // corner needs I(0,last); a bottom-row pixel needs I(0,col)
    assign rd_addr = (cls == CL_CORNER) ? i_geom.lc[COL_AW-1:0] : i_pix_col[COL_AW-1:0];

    always_ff @(posedge i_clk) begin
        if (accept && in_range && i_pix_row == '0) begin
            r_top_mem[wr_addr] <= pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && in_range && i_pix_row == '0 && i_pix_col == '0) begin
            r_top_first <= pix;
        end
        if (accept) begin
            r_s1.cls <= cls;
            r_s1.row <= i_pix_row;
            r_s1.col <= i_pix_col;
            r_s1.p   <= pix;
            r_s1.m   <= r_top_mem[rd_addr];
            r_s1.d   <= r_row_first;
            r_s1.a   <= r_top_first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_row_first <= '0;
        end else begin
            if (accept) begin
                // pixels without results stop here
                r_s1_valid <= (cls != CL_NONE);
            end else if (o_push) begin
                r_s1_valid <= 1'b0;
            end
            if (accept && in_range && i_pix_col == '0) begin
                r_row_first <= pix;
            end
        end
    end

    assign o_push = r_s1_valid & ~i_q_full;
    assign o_job  = r_s1;

endmodule

[hdl/pbi_fifo.sv]
// ----------------------------------------------------------------------------
// pbi_fifo: job queue
// Short first-in first-out queue that decouples intake from result issue.
// ----------------------------------------------------------------------------
module pbi_fifo
    import pbi_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_head,
    output logic o_full,
    output logic o_empty
);

    t_job            r_slot [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_CW-1:0] r_count;

    assign o_full  = (r_count == Q_CW'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[hdl/pbi_back.sv]
// ----------------------------------------------------------------------------
// pbi_back: boundary value issue
// Steps through the two or four results of each job and computes each value
// with one three-operand add into the output register.
// ----------------------------------------------------------------------------
module pbi_back
    import pbi_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_geom                   i_geom,
    input  t_job                    i_job,
    input  logic                    i_q_empty,
    output logic                    o_pop,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [POS_W-1:0]        o_out_row,
    output logic [POS_W-1:0]        o_out_col,
    output logic signed [VAL_W-1:0] o_out_re,
    output logic signed [VAL_W-1:0] o_out_im,
    output logic                    o_out_last
);

    localparam logic [1:0] K_EDGE_LAST   = 2'd1;
    localparam logic [1:0] K_CORNER_LAST = 2'd3;

    logic [1:0]              r_k;
    logic                    r_out_valid;
    logic [POS_W-1:0]        r_out_row;
    logic [POS_W-1:0]        r_out_col;
    logic signed [VAL_W-1:0] r_out_re;
    logic signed [VAL_W-1:0] r_out_im;
    logic                    r_out_last;

    logic                    load;
    logic                    k_last;
    t_cval                   opx;
    t_cval                   opy;
    t_cval                   opz;
    t_cval                   edge_op;
    logic                    dbl;
    logic [POS_W-1:0]        res_row;
    logic [POS_W-1:0]        res_col;
    logic                    res_last;
    logic signed [VAL_W-1:0] y_re;
    logic signed [VAL_W-1:0] y_im;
    logic signed [VAL_W-1:0] res_re;
    logic signed [VAL_W-1:0] res_im;

    assign load   = ~i_q_empty & (~r_out_valid | ~i_out_stall);
    assign k_last = (i_job.cls == CL_CORNER) ? (r_k == K_CORNER_LAST) : (r_k == K_EDGE_LAST);
    assign o_pop  = load & k_last;

    assign edge_op = (i_job.cls == CL_BOT) ? i_job.m : i_job.d;

    // value = x + z - y, with y doubled for corners
    always_comb begin
        opx      = i_job.p;
        opy      = edge_op;
        opz      = '0;
        dbl      = 1'b0;
        res_row  = i_job.row;
        res_col  = i_job.col;
        res_last = 1'b0;
        unique case (i_job.cls) inside
            CL_BOT, CL_LCOL: begin
                if (r_k[0]) begin
                    opx = edge_op;
                    opy = i_job.p;
                end
                if (i_job.cls == CL_BOT) begin
                    res_row = r_k[0] ? i_geom.lr : '0;
                end else begin
                    res_col = r_k[0] ? i_geom.lc : '0;
                end
            end
            CL_CORNER: begin
                dbl = 1'b1;
                unique case (r_k)
                    2'd0: begin
                        opx = i_job.m; opy = i_job.a; opz = i_job.d;
                        res_row = '0; res_col = '0;
                    end
                    2'd1: begin
                        opx = i_job.a; opy = i_job.m; opz = i_job.p;
                        res_row = '0; res_col = i_geom.lc;
                    end
                    2'd2: begin
                        opx = i_job.a; opy = i_job.d; opz = i_job.p;
                        res_row = i_geom.lr; res_col = '0;
                    end
                    default: begin
                        opx = i_job.m; opy = i_job.p; opz = i_job.d;
                        res_row = i_geom.lr; res_col = i_geom.lc;
                        res_last = 1'b1;
                    end
                endcase
            end
            default: ;
        endcase
    end

    always_comb begin
        y_re = dbl ? {opy.re[SAMPLE_BITS-1], opy.re, 1'b0}
                   : {{2{opy.re[SAMPLE_BITS-1]}}, opy.re};
        y_im = dbl ? {opy.im[SAMPLE_BITS-1], opy.im, 1'b0}
                   : {{2{opy.im[SAMPLE_BITS-1]}}, opy.im};
        res_re = {{2{opx.re[SAMPLE_BITS-1]}}, opx.re}
               + {{2{opz.re[SAMPLE_BITS-1]}}, opz.re} - y_re;
        res_im = {{2{opx.im[SAMPLE_BITS-1]}}, opx.im}
               + {{2{opz.im[SAMPLE_BITS-1]}}, opz.im} - y_im;
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_row  <= res_row;
            r_out_col  <= res_col;
            r_out_re   <= res_re;
            r_out_im   <= res_im;
            r_out_last <= res_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_k         <= k_last ? 2'd0 : r_k + 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_out_re    = r_out_re;
    assign o_out_im    = r_out_im;
    assign o_out_last  = r_out_last;

endmodule

[sim/tb_periodic_boundary_image_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_periodic_boundary_image_core: self-checking bench for the boundary core
// Streams raster images of random size and content, plus noise, gaps and
// broken sequences, through the core under four idling mixes. Every boundary
// entry is predicted from a local copy of the top row and row-first pixel.
// ----------------------------------------------------------------------------
module tb_periodic_boundary_image_core;
    import pbi_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RST_CYCLES   = 11;
    localparam int RAND_ITEMS   = 400;
    localparam int LIMIT_CYCLES = 500000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 12;   // pipeline latency plus a full job queue
    localparam int MAX_REPORTS  = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef enum int {IMG_CLEAN, IMG_NOISE, IMG_SKIP, IMG_TRUNC} t_img_style;

    typedef struct {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        t_cval            val;
    } t_pixel;

    typedef struct {
        logic [POS_W-1:0]        row;
        logic [POS_W-1:0]        col;
        logic signed [VAL_W-1:0] re;
        logic signed [VAL_W-1:0] im;
        logic                    last;
    } t_boundary;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]          i_cfg_index = '0;
    logic [SIZE_W-1:0]             i_cfg_data  = '0;
    logic                          i_in_valid  = 1'b0;
    logic [POS_W-1:0]              i_pix_row   = '0;
    logic [POS_W-1:0]              i_pix_col   = '0;
    logic signed [SAMPLE_BITS-1:0] i_pix_re    = '0;
    logic signed [SAMPLE_BITS-1:0] i_pix_im    = '0;
    logic                          i_out_stall = 1'b0;
    logic                          o_cfg_ready;
    logic                          o_in_stall;
    logic                          o_out_valid;
    logic [POS_W-1:0]              o_out_row;
    logic [POS_W-1:0]              o_out_col;
    logic signed [VAL_W-1:0]       o_out_re;
    logic signed [VAL_W-1:0]       o_out_im;
    logic                          o_out_last;

    // pending pixels, expected boundary entries
    t_pixel    pix_q[$];
    t_boundary boundary_q[$];

    // predictor state
    logic [SIZE_W-1:0] cfg_rows = SIZE_W'(MAX_ROWS);
    logic [SIZE_W-1:0] cfg_cols = SIZE_W'(MAX_COLS);
    t_cval             top_row[MAX_COLS];
    t_cval             row_first = '0;
    bit                top_written[MAX_COLS];

    int     idle_pct  = 0;
    int     stall_pct = 0;
    int     hold_left = 0;
    bit     pix_taken = 1'b0;
    t_pixel drv_px;

    int err_cnt      = 0;
    int cycle_cnt    = 0;
    int items_queued = 0;
    int pix_cnt      = 0;
    int res_cnt      = 0;
    int cfg_cnt      = 0;

    int idle_mix[4]  = '{0, 64, 0, 15};
    int stall_mix[4] = '{0, 0, 64, 15};

    periodic_boundary_image_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_pix_row   (i_pix_row),
        .i_pix_col   (i_pix_col),
        .i_pix_re    (i_pix_re),
        .i_pix_im    (i_pix_im),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_out_re    (o_out_re),
        .o_out_im    (o_out_im),
        .o_out_last  (o_out_last)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic int sx(input logic signed [SAMPLE_BITS-1:0] v);
        return int'(v);
    endfunction

    function automatic int eff_size(input logic [SIZE_W-1:0] v, input int maxv);
        if (v < 2)
            return 2;
        if (v > maxv)
            return maxv;
        return int'(v);
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(7))
            0:       return SAMPLE_MIN;
            1:       return SAMPLE_MAX;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic void add_boundary(input int r, input int c, input int re,
                                         input int im, input logic last);
        t_boundary e;
        e.row  = POS_W'(r);
        e.col  = POS_W'(c);
        e.re   = VAL_W'(re);
        e.im   = VAL_W'(im);
        e.last = last;
        boundary_q.push_back(e);
    endfunction

    // boundary entries caused by one accepted pixel
    function automatic void predict_boundary(input t_pixel px);
        int    rows, cols, lr, lc;
        int    pre, pim, dre, dim;
        t_cval a, b, d;
        rows = eff_size(cfg_rows, MAX_ROWS);
        cols = eff_size(cfg_cols, MAX_COLS);
        lr   = rows - 1;
        lc   = cols - 1;
        if (px.row >= rows || px.col >= cols)
            return;
        if (px.row == 0)
            top_row[px.col] = px.val;
        if (px.col == 0)
            row_first = px.val;
        pre = sx(px.val.re);
        pim = sx(px.val.im);
        if (px.row == lr && px.col > 0 && px.col < lc) begin
            dre = pre - sx(top_row[px.col].re);
            dim = pim - sx(top_row[px.col].im);
            add_boundary(0, px.col, dre, dim, 1'b0);
            add_boundary(lr, px.col, -dre, -dim, 1'b0);
        end else if (px.col == lc && px.row > 0 && px.row < lr) begin
            dre = pre - sx(row_first.re);
            dim = pim - sx(row_first.im);
            add_boundary(px.row, 0, dre, dim, 1'b0);
            add_boundary(px.row, lc, -dre, -dim, 1'b0);
        end else if (px.row == lr && px.col == lc) begin
            a = top_row[0];
            b = top_row[lc];
            d = row_first;
            add_boundary(0, 0, sx(b.re) - 2 * sx(a.re) + sx(d.re),
                         sx(b.im) - 2 * sx(a.im) + sx(d.im), 1'b0);
            add_boundary(0, lc, sx(a.re) - 2 * sx(b.re) + pre,
                         sx(a.im) - 2 * sx(b.im) + pim, 1'b0);
            add_boundary(lr, 0, sx(a.re) - 2 * sx(d.re) + pre,
                         sx(a.im) - 2 * sx(d.im) + pim, 1'b0);
            add_boundary(lr, lc, sx(b.re) - 2 * pre + sx(d.re),
                         sx(b.im) - 2 * pim + sx(d.im), 1'b1);
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name,
                         $signed(want), $signed(got));
        end
    endfunction

    // queue a pixel; positions whose store read would hit a never-written
    // top row entry are dropped
    task automatic queue_pixel(input int r, input int c,
                               input logic signed [SAMPLE_BITS-1:0] re,
                               input logic signed [SAMPLE_BITS-1:0] im);
        int     rows, cols;
        t_pixel px;
        rows = eff_size(cfg_rows, MAX_ROWS);
        cols = eff_size(cfg_cols, MAX_COLS);
        if (r < rows && c < cols) begin
            if (r == rows - 1 && c > 0 && c < cols - 1 && !top_written[c])
                return;
            if (r == rows - 1 && c == cols - 1 && !(top_written[0] && top_written[cols-1]))
                return;
            if (r == 0)
                top_written[c] = 1'b1;
            items_queued++;
        end
        px.row    = POS_W'(r);
        px.col    = POS_W'(c);
        px.val.re = re;
        px.val.im = im;
        pix_q.push_back(px);
    endtask

    task automatic send_image(input t_img_style style);
        int rows, cols, stop_at, n, r, c;
        rows    = eff_size(cfg_rows, MAX_ROWS);
        cols    = eff_size(cfg_cols, MAX_COLS);
        stop_at = (style == IMG_TRUNC) ? $urandom_range(rows * cols - 1) : rows * cols;
        n       = 0;
        for (r = 0; r < rows; r++) begin
            for (c = 0; c < cols; c++) begin
                if (n < stop_at && !(style == IMG_SKIP && $urandom_range(4) == 0))
                    queue_pixel(r, c, rand_sample(), rand_sample());
                if (style == IMG_NOISE && $urandom_range(5) == 0) begin
                    case ($urandom_range(2))
                        0: queue_pixel($urandom_range(1023, rows), $urandom_range(1023),
                                       rand_sample(), rand_sample());
                        1: queue_pixel($urandom_range(1023), $urandom_range(1023, cols),
                                       rand_sample(), rand_sample());
                        default: queue_pixel($urandom_range(rows - 1),
                                             $urandom_range(cols - 1),
                                             rand_sample(), rand_sample());
                    endcase
                end
                n++;
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            CFG_NUM_ROWS: cfg_rows = val;
            CFG_NUM_COLS: cfg_cols = val;
            default: ;
        endcase
        cfg_cnt++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // wait for every pending pixel and expected result, then let the core settle
    task automatic drain_all();
        while (pix_q.size() != 0 || i_in_valid || boundary_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // pixel driver
    always @(negedge i_clk) begin
        if (!i_in_valid || pix_taken) begin
            if (pix_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                drv_px = pix_q.pop_front();
                i_in_valid <= 1'b1;
                i_pix_row  <= drv_px.row;
                i_pix_col  <= drv_px.col;
                i_pix_re   <= drv_px.val.re;
                i_pix_im   <= drv_px.val.im;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off countdown
    always @(negedge i_clk) begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    always @(negedge i_clk) begin
        i_out_stall <= (hold_left > 0) || ($urandom_range(99) < stall_pct);
    end

    // monitor: check results, then predict from the accepted pixel
    always @(posedge i_clk) begin
        t_boundary want;
        t_pixel    px;
        pix_taken = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid === 1'b1 && !i_out_stall) begin
                res_cnt++;
                if (boundary_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("%0t: unexpected result, expected none, got (%0d,%0d) %0d %0d",
                                 $time, o_out_row, o_out_col, o_out_re, o_out_im);
                end else begin
                    want = boundary_q.pop_front();
                    check_field("row", want.row, o_out_row);
                    check_field("col", want.col, o_out_col);
                    check_field("re", want.re, o_out_re);
                    check_field("im", want.im, o_out_im);
                    check_field("last", want.last, o_out_last);
                end
            end
            if (i_in_valid && o_in_stall === 1'b0) begin
                pix_taken  = 1'b1;
                pix_cnt++;
                px.row     = i_pix_row;
                px.col     = i_pix_col;
                px.val.re  = i_pix_re;
                px.val.im  = i_pix_im;
                predict_boundary(px);
            end
        end
    end

    initial begin : watchdog
        while (cycle_cnt < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles, %0d results still expected, %0d pixels pending",
                 cycle_cnt, boundary_q.size(), pix_q.size());
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        int         ph, seg, img, n_img, target, k;
        int         rows_w, cols_w;
        t_img_style style;

        repeat (RST_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // reset geometry 1024 x 1024: extreme positions and sample values
        queue_pixel(0, 0, SAMPLE_MIN, SAMPLE_MAX);
        queue_pixel(0, 1, SAMPLE_MAX, SAMPLE_MIN);
        queue_pixel(0, 512, rand_sample(), rand_sample());
        queue_pixel(0, 1022, rand_sample(), rand_sample());
        queue_pixel(0, 1023, SAMPLE_MAX, SAMPLE_MIN);
        queue_pixel(1023, 1, SAMPLE_MIN, SAMPLE_MAX);
        queue_pixel(1023, 512, rand_sample(), rand_sample());
        queue_pixel(1023, 1022, SAMPLE_MAX, SAMPLE_MAX);
        queue_pixel(5, 0, rand_sample(), rand_sample());
        queue_pixel(5, 1023, rand_sample(), rand_sample());
        queue_pixel(1022, 0, SAMPLE_MAX, SAMPLE_MIN);
        queue_pixel(1022, 1023, SAMPLE_MIN, SAMPLE_MAX);
        queue_pixel(1023, 0, SAMPLE_MAX, SAMPLE_MIN);   // corner, but not the final one
        queue_pixel(1023, 1023, SAMPLE_MIN, SAMPLE_MAX);
        drain_all();

        // sizes below the minimum clamp to a 2 x 2 image; out-of-image pixels ignored
        write_reg(CFG_NUM_ROWS, 11'd0);
        write_reg(CFG_NUM_COLS, 11'd1);
        queue_pixel(0, 0, SAMPLE_MAX, SAMPLE_MAX);
        queue_pixel(0, 1, SAMPLE_MIN, SAMPLE_MIN);
        queue_pixel(2, 0, rand_sample(), rand_sample());
        queue_pixel(0, 2, rand_sample(), rand_sample());
        queue_pixel(1, 0, SAMPLE_MAX, SAMPLE_MAX);
        queue_pixel(1, 1, SAMPLE_MIN, SAMPLE_MIN);
        drain_all();

        // unused register indexes must leave the geometry alone
        write_reg(CFG_SPARE_2, 11'd2047);
        write_reg(CFG_SPARE_3, 11'd5);
        queue_pixel(1, 1, rand_sample(), rand_sample());
        drain_all();

        // sizes above the maximum clamp to 1024
        write_reg(CFG_NUM_ROWS, 11'd2047);
        write_reg(CFG_NUM_COLS, 11'd1024);
        queue_pixel(1023, 1023, rand_sample(), rand_sample());
        drain_all();

        for (ph = 0; ph < 4; ph++) begin
            idle_pct  = idle_mix[ph];
            stall_pct = stall_mix[ph];
            target    = items_queued + RAND_ITEMS / 4;
            seg       = 0;
            while (items_queued < target) begin
                case ($urandom_range(9))
                    0, 1: begin rows_w = 2; cols_w = $urandom_range(40, 9); end
                    2:    begin rows_w = $urandom_range(40, 9); cols_w = 2; end
                    3:    begin rows_w = $urandom_range(1, 0); cols_w = $urandom_range(6, 2); end
                    default: begin
                        rows_w = $urandom_range(8, 2);
                        cols_w = $urandom_range(8, 2);
                    end
                endcase
                if (ph == 0 && seg == 0) begin
                    rows_w = 6;
                    cols_w = 6;
                end
                write_reg(CFG_NUM_ROWS, SIZE_W'(rows_w));
                write_reg(CFG_NUM_COLS, SIZE_W'(cols_w));
                if (ph == 0 && seg == 0) begin
                    // receiver holds off while a whole image is offered back to back
                    @(posedge i_clk);
                    hold_left = HOLD_CYCLES;
                    send_image(IMG_CLEAN);
                end else begin
                    n_img = $urandom_range(3, 1);
                    for (img = 0; img < n_img && items_queued < target; img++) begin
                        k = $urandom_range(19);
                        style = (k < 12) ? IMG_CLEAN : (k < 15) ? IMG_NOISE :
                                (k < 18) ? IMG_SKIP : IMG_TRUNC;
                        send_image(style);
                        if ($urandom_range(3) == 0)
                            drain_all();
                    end
                end
                drain_all();
                seg++;
            end
        end

        idle_pct  = 0;
        stall_pct = 0;
        drain_all();

        $display("summary: %0d pixels and %0d boundary results checked, %0d register writes",
                 pix_cnt, res_cnt, cfg_cnt);
        $display("summary: four idling mixes, one long output hold-off, clamped sizes, noise");
        if (err_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[files.f]
hdl/pbi_pkg.sv
hdl/pbi_front.sv
hdl/pbi_fifo.sv
hdl/pbi_back.sv
hdl/periodic_boundary_image_core.sv
sim/tb_periodic_boundary_image_core.sv
